// File: hdl/ssup_pkg.sv
package ssup_pkg;

   // Reset value of the watchdog timeout register
   localparam logic [15:0] WATCHDOG_RESET_MS = 16'd120;

   // Command codes carried by a request
   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_ARM     = 2'd1,
      CMD_DISARM  = 2'd2,
      CMD_SETMODE = 2'd3
   } cmd_type;

   // Supervisor state, one-hot
   typedef enum logic [3:0] {
      ST_DISARMED = 4'b0001,
      ST_ARMED    = 4'b0010,
      ST_RUNNING  = 4'b0100,
      ST_FAULT    = 4'b1000
   } state_type;

   // Reported state codes
   localparam logic [1:0] CODE_DISARMED = 2'd0;
   localparam logic [1:0] CODE_ARMED    = 2'd1;
   localparam logic [1:0] CODE_RUNNING  = 2'd2;
   localparam logic [1:0] CODE_FAULT    = 2'd3;

   // Mode values
   localparam logic RUN_MANUAL = 1'b0;
   localparam logic RUN_AUTO   = 1'b1;

   // Held supervisor context
   typedef struct packed {
      state_type   state;
      logic        mode;
      logic [31:0] last_beat_ms;
      logic        estop_seen;
   } sup_ctx_type;

   // One request as held in the input register
   typedef struct packed {
      logic [31:0] now_ms;
      cmd_type     cmd;
      logic        mode_value;
      logic        estop_level;
      logic        heartbeat_seen;
      logic [31:0] heartbeat_time_ms;
   } req_type;

   // One result
   typedef struct packed {
      logic [1:0] sys_state;
      logic       run_mode;
      logic       state_moved;
      logic       mode_moved;
      logic       cmd_done;
      logic       stop_and_center;
      logic       emergency;
      logic       estop_pressed;
      logic       stop_released;
      logic       watchdog_fired;
   } rsp_type;

   // Map the one-hot state onto its reported code
   function automatic logic [1:0] state_code(input state_type st);
      logic [1:0] code;
      unique case (st)
         ST_DISARMED: code = CODE_DISARMED;
         ST_ARMED:    code = CODE_ARMED;
         ST_RUNNING:  code = CODE_RUNNING;
         ST_FAULT:    code = CODE_FAULT;
         default:     code = CODE_FAULT;
      endcase
      return code;
   endfunction

endpackage

// File: hdl/ssup_step.sv
module ssup_step
   import ssup_pkg::*;
(
   input  req_type     req,
   input  sup_ctx_type ctx,
   input  logic [15:0] timeout_ms,
   output sup_ctx_type ctx_next,
   output rsp_type     rsp
);

   logic [31:0] beat_ms;
   state_type   st_cmd;
   logic        mode_cmd;
   logic [31:0] beat_cmd;
   logic        mode_chg;
   logic        done;
   logic        stop_ctr;
   state_type   st_stop;
   logic        seen_next;
   logic        pressed;
   logic        released;
   logic [31:0] age_ms;
   logic        beat_held;
   logic        fired;
   state_type   st_wd;
   state_type   st_final;

   // Take the heartbeat timestamp
   assign beat_ms = req.heartbeat_seen ? req.heartbeat_time_ms : ctx.last_beat_ms;

   // Apply the command
   always_comb begin
      st_cmd   = ctx.state;
      mode_cmd = ctx.mode;
      beat_cmd = beat_ms;
      mode_chg = 1'b0;
      done     = 1'b0;
      stop_ctr = 1'b0;
      unique case (req.cmd)
         CMD_NONE: begin
         end
         CMD_ARM: begin
            if (ctx.state == ST_DISARMED) begin
               st_cmd   = ST_ARMED;
               beat_cmd = req.now_ms;
               done     = 1'b1;
            end
         end
         CMD_DISARM: begin
            if (ctx.state != ST_DISARMED) begin
               st_cmd   = ST_DISARMED;
               stop_ctr = 1'b1;
               done     = 1'b1;
            end
         end
         CMD_SETMODE: begin
            if (req.mode_value != ctx.mode) begin
               mode_cmd = req.mode_value;
               if (req.mode_value == RUN_AUTO) begin
                  beat_cmd = 32'd0;
               end
               mode_chg = 1'b1;
               done     = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Detect emergency-stop edges; a press forces fault
   always_comb begin
      st_stop   = st_cmd;
      seen_next = ctx.estop_seen;
      pressed   = 1'b0;
      released  = 1'b0;
      if (req.estop_level && !ctx.estop_seen) begin
         seen_next = 1'b1;
         pressed   = 1'b1;
         st_stop   = ST_FAULT;
      end else if (!req.estop_level && ctx.estop_seen) begin
         seen_next = 1'b0;
         released  = 1'b1;
      end
   end

   // Heartbeat age, modulo 2^32
   assign age_ms    = req.now_ms - beat_cmd;
   assign beat_held = (beat_cmd != 32'd0);

   // Watchdog check in auto mode
   assign fired = (mode_cmd == RUN_AUTO) && (st_stop != ST_DISARMED) && beat_held &&
                  (age_ms > {16'd0, timeout_ms});
   assign st_wd = fired ? ST_FAULT : st_stop;

   // Promote armed to running
   always_comb begin
      st_final = st_wd;
      if (st_wd == ST_ARMED) begin
         if (mode_cmd == RUN_AUTO) begin
            if (beat_held && (age_ms < {16'd0, timeout_ms})) begin
               st_final = ST_RUNNING;
            end
         end else begin
            st_final = ST_RUNNING;
         end
      end
   end

   // Collect next context and result
   always_comb begin
      ctx_next.state        = st_final;
      ctx_next.mode         = mode_cmd;
      ctx_next.last_beat_ms = beat_cmd;
      ctx_next.estop_seen   = seen_next;

      rsp.sys_state       = state_code(st_final);
      rsp.run_mode        = mode_cmd;
      rsp.state_moved     = (st_final != ctx.state);
      rsp.mode_moved      = mode_chg;
      rsp.cmd_done        = done;
      rsp.stop_and_center = stop_ctr;
      rsp.emergency       = pressed | fired;
      rsp.estop_pressed   = pressed;
      rsp.stop_released   = released;
      rsp.watchdog_fired  = fired;
   end

endmodule

// File: hdl/safety_supervisor_fsm.sv
// An accepted request reaches its response through the input register, then the response register.
// Throughput: one request per cycle unless the response stalls; the supervisor context updates in
// the same cycle that a response register is loaded, so consecutive requests follow back to back.
// Reset (synchronous, active high): state armed, mode manual, no heartbeat held,
// emergency stop released, watchdog timeout 120 ms, both stages empty.
module safety_supervisor_fsm
   import ssup_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_now_ms,
   input  logic [1:0]  req_cmd,
   input  logic        req_mode_value,
   input  logic        req_estop_level,
   input  logic        req_heartbeat_seen,
   input  logic [31:0] req_heartbeat_time_ms,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_sys_state,
   output logic        rsp_sys_mode,
   output logic        rsp_state_changed,
   output logic        rsp_mode_changed,
   output logic        rsp_cmd_done,
   output logic        rsp_stop_and_center,
   output logic        rsp_emergency,
   output logic        rsp_estop_pressed,
   output logic        rsp_estop_released,
   output logic        rsp_watchdog_fired
);

   logic [15:0] timeout_ff;
   logic        req_valid_ff;
   req_type     req_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   sup_ctx_type ctx_ff;
   sup_ctx_type ctx_in;
   rsp_type     rsp_in;
   logic        advance;
   logic        load_req;

   // Stage handshake
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign load_req  = !req_valid_ff || advance;
   assign req_stall = !load_req;

   // Hold the watchdog timeout
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= WATCHDOG_RESET_MS;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (load_req) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_req && req_valid) begin
         req_ff.now_ms            <= req_now_ms;
         req_ff.cmd               <= cmd_type'(req_cmd);
         req_ff.mode_value        <= req_mode_value;
         req_ff.estop_level       <= req_estop_level;
         req_ff.heartbeat_seen    <= req_heartbeat_seen;
         req_ff.heartbeat_time_ms <= req_heartbeat_time_ms;
      end
   end

   // Evaluate one tick
   ssup_step u_step (
      .req        (req_ff),
      .ctx        (ctx_ff),
      .timeout_ms (timeout_ff),
      .ctx_next   (ctx_in),
      .rsp        (rsp_in)
   );

   // Advance the supervisor context
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.state        <= ST_ARMED;
         ctx_ff.mode         <= RUN_MANUAL;
         ctx_ff.last_beat_ms <= 32'd0;
         ctx_ff.estop_seen   <= 1'b0;
      end else if (advance) begin
         ctx_ff <= ctx_in;
      end
   end

   // Load the response register; drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sys_state       = rsp_ff.sys_state;
   assign rsp_sys_mode        = rsp_ff.run_mode;
   assign rsp_state_changed   = rsp_ff.state_moved;
   assign rsp_mode_changed    = rsp_ff.mode_moved;
   assign rsp_cmd_done        = rsp_ff.cmd_done;
   assign rsp_stop_and_center = rsp_ff.stop_and_center;
   assign rsp_emergency       = rsp_ff.emergency;
   assign rsp_estop_pressed   = rsp_ff.estop_pressed;
   assign rsp_estop_released  = rsp_ff.stop_released;
   assign rsp_watchdog_fired  = rsp_ff.watchdog_fired;

endmodule
